FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the maze path shortener.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/msp_pkg.sv
// Package of the maze path shortener: beat types, symbol codes and the
// three-symbol replacement table. Depends on nothing.
package msp_pkg;

    localparam logic [7:0] SYM_L = 8'h4C;
    localparam logic [7:0] SYM_R = 8'h52;
    localparam logic [7:0] SYM_S = 8'h53;
    localparam logic [7:0] SYM_B = 8'h42;

    localparam int unsigned SYM_W     = 8;
    localparam int unsigned LEN_W     = 24;
    localparam int unsigned OUT_LEN_W = 26;

    typedef struct packed {
        logic [SYM_W-1:0] turn_symbol;
        logic [LEN_W-1:0] segment_length;
        logic             end_of_path;
    } msp_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]     out_symbol;
        logic [OUT_LEN_W-1:0] out_length;
        logic                 path_done;
    } msp_result_t;

    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] repl;
    } msp_match_t;

    // A triple matches only with a back turn in the middle; the outer pair
    // then selects the replacement.
    function automatic msp_match_t msp_find_rule(
        input logic [SYM_W-1:0] a,
        input logic [SYM_W-1:0] b,
        input logic [SYM_W-1:0] c
    );
        msp_match_t m;
        m.hit  = 1'b0;
        m.repl = SYM_B;
        if (b == SYM_B)
        begin
            case ({a, c})
                {SYM_L, SYM_R}: begin m.hit = 1'b1; m.repl = SYM_B; end
                {SYM_R, SYM_L}: begin m.hit = 1'b1; m.repl = SYM_B; end
                {SYM_S, SYM_S}: begin m.hit = 1'b1; m.repl = SYM_B; end
                {SYM_L, SYM_S}: begin m.hit = 1'b1; m.repl = SYM_R; end
                {SYM_S, SYM_L}: begin m.hit = 1'b1; m.repl = SYM_R; end
                {SYM_L, SYM_L}: begin m.hit = 1'b1; m.repl = SYM_S; end
                {SYM_R, SYM_R}: begin m.hit = 1'b1; m.repl = SYM_S; end
                {SYM_S, SYM_R}: begin m.hit = 1'b1; m.repl = SYM_L; end
                {SYM_R, SYM_S}: begin m.hit = 1'b1; m.repl = SYM_L; end
                default:        begin m.hit = 1'b0; m.repl = SYM_B; end
            endcase
        end
        return m;
    endfunction

endpackage

FILE: src/maze_path_shortener.sv
// Maze path shortener, top level: a two-entry symbol window and one
// result register. Depends on msp_pkg and assert_macros.svh.
//
// The block takes one beat per cycle while item_stall is low; it stalls
// in a flush and while the window is full and the result register waits.
// A result of the window step appears in the cycle after the beat that
// causes it. A beat with end_of_path set that leaves one or two symbols in
// the window is followed by a flush of those symbols, one at a time through
// the single result register, in which no beat is taken. A beat that brings
// no result is taken even while the result register waits on a stall.
`include "assert_macros.svh"

module maze_path_shortener
    import msp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  msp_item_t   item,
    output logic        result_valid,
    input  logic        result_stall,
    output msp_result_t result
);

    logic [SYM_W-1:0] win_sym_reg [2];
    logic [SYM_W-1:0] win_sym_next [2];
    logic [LEN_W-1:0] win_len_reg [2];
    logic [LEN_W-1:0] win_len_next [2];
    logic [1:0]       count_reg, count_next;
    logic             flush_reg, flush_next;
    logic             out_valid_reg, out_valid_next;
    msp_result_t      out_reg, out_next;

    logic             out_free;
    logic             accept;
    msp_match_t       match;
    logic [OUT_LEN_W-1:0] sum;

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = flush_reg || (count_reg == 2'd2 && !out_free);
    assign accept       = item_valid && !item_stall;
    assign match        = msp_find_rule(win_sym_reg[0], win_sym_reg[1], item.turn_symbol);
    assign sum          = OUT_LEN_W'(win_len_reg[0]) + OUT_LEN_W'(win_len_reg[1])
                        + OUT_LEN_W'(item.segment_length);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        win_sym_next   = win_sym_reg;
        win_len_next   = win_len_reg;
        count_next     = count_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        if (accept)
        begin
            if (count_reg == 2'd2)
            begin
                out_valid_next = 1'b1;
                if (match.hit)
                begin
                    out_next.out_symbol = match.repl;
                    out_next.out_length = sum;
                    out_next.path_done  = item.end_of_path;
                    count_next          = 2'd0;
                end
                else
                begin
                    out_next.out_symbol = win_sym_reg[0];
                    out_next.out_length = OUT_LEN_W'(win_len_reg[0]);
                    out_next.path_done  = 1'b0;
                    win_sym_next[0]     = win_sym_reg[1];
                    win_len_next[0]     = win_len_reg[1];
                    win_sym_next[1]     = item.turn_symbol;
                    win_len_next[1]     = item.segment_length;
                    flush_next          = item.end_of_path;
                end
            end
            else
            begin
                win_sym_next[count_reg[0]] = item.turn_symbol;
                win_len_next[count_reg[0]] = item.segment_length;
                count_next                 = count_reg + 2'd1;
                flush_next                 = item.end_of_path;
            end
        end
        else if (flush_reg && out_free)
        begin
            out_valid_next      = 1'b1;
            out_next.out_symbol = win_sym_reg[0];
            out_next.out_length = OUT_LEN_W'(win_len_reg[0]);
            out_next.path_done  = (count_reg == 2'd1);
            win_sym_next[0]     = win_sym_reg[1];
            win_len_next[0]     = win_len_reg[1];
            count_next          = count_reg - 2'd1;
            flush_next          = (count_reg != 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= 2'd0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_sym_reg <= win_sym_next;
        win_len_reg <= win_len_next;
        out_reg     <= out_next;
    end

    `ASSERT_NEVER(a_flush_empty, flush_reg && count_reg == 2'd0, "flush with empty window")
    `ASSERT_NEVER(a_count_range, count_reg == 2'd3, "window count out of range")
    `ASSERT_CLK(a_hit_last_done,
        accept && count_reg == 2'd2 && match.hit && item.end_of_path |=>
        result_valid && result.path_done && count_reg == 2'd0 && !flush_reg,
        "final replacement not marked done")
    `ASSERT_CLK(a_flush_end,
        flush_reg && count_reg == 2'd1 && out_free |=>
        result_valid && result.path_done && !flush_reg,
        "last flushed symbol not marked done")

endmodule
